// ===== rtl/core/cmac_pkg.sv =====
// Shared types, constants and AES helper functions for the CMAC engine.
package cmac_pkg;

   localparam logic [1:0] CSR_KEY_HIGH = 2'd0;
   localparam logic [1:0] CSR_KEY_LOW  = 2'd1;
   localparam logic [1:0] CSR_IV_HIGH  = 2'd2;
   localparam logic [1:0] CSR_IV_LOW   = 2'd3;

   localparam logic [7:0] GF_REDUCE = 8'h87;
   localparam logic [7:0] PAD_BYTE  = 8'h80;
   localparam logic [4:0] FULL_BYTES = 5'd16;

   // One classified block as it travels from the front end to the back end.
   typedef struct packed {
      logic [127:0] data;      // padded message block, subkey not yet applied
      logic         use_k1;
      logic         use_k2;
      logic         restart;
      logic         final_block;
   } blk_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] t [0:255];
      t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[a];
   endfunction

   function automatic logic [7:0] xt(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte i of a 128-bit word, byte 0 in the top bits.
   function automatic logic [7:0] byte_of(input logic [127:0] w, input int i);
      return w[127 - 8 * i -: 8];
   endfunction

   // Next round key from the current one.
   function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rcon);
      logic [7:0] b [0:15];
      logic [127:0] r;
      for (int i = 0; i < 16; i++) b[i] = byte_of(k, i);
      b[0] = b[0] ^ sbox(b[13]) ^ rcon;
      b[1] = b[1] ^ sbox(b[14]);
      b[2] = b[2] ^ sbox(b[15]);
      b[3] = b[3] ^ sbox(b[12]);
      for (int i = 4; i < 16; i++) b[i] = b[i] ^ b[i - 4];
      for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = b[i];
      return r;
   endfunction

   // One AES round without the key addition; MixColumns skipped on the last round.
   function automatic logic [127:0] round_core(input logic [127:0] st, input logic last);
      logic [7:0] s [0:15];
      logic [7:0] t [0:15];
      logic [7:0] a0, a1, a2, a3, x;
      logic [127:0] r;
      for (int i = 0; i < 16; i++) s[i] = sbox(byte_of(st, i));
      for (int c = 0; c < 4; c++)
         for (int i = 0; i < 4; i++) t[i + 4 * c] = s[i + 4 * ((c + i) & 3)];
      if (!last) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
            x = a0 ^ a1 ^ a2 ^ a3;
            t[4 * c]     = a0 ^ x ^ xt(a0 ^ a1);
            t[4 * c + 1] = a1 ^ x ^ xt(a1 ^ a2);
            t[4 * c + 2] = a2 ^ x ^ xt(a2 ^ a3);
            t[4 * c + 3] = a3 ^ x ^ xt(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = t[i];
      return r;
   endfunction

   // Doubling in GF(2^128).
   function automatic logic [127:0] gf_dbl(input logic [127:0] a);
      return {a[126:0], 1'b0} ^ {120'd0, (a[127] ? GF_REDUCE : 8'h00)};
   endfunction

endpackage

// ===== rtl/core/cmac_front.sv =====
// Front end: accepts request blocks, applies padding and selects the subkey.
module cmac_front
   import cmac_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [63:0]  req_block_high,
   input  logic [63:0]  req_block_low,
   input  logic [4:0]   req_valid_bytes,
   input  logic         req_final_block,
   input  logic         req_restart,
   output logic         q_valid,
   output blk_type      q_data,
   input  logic         q_pop
);
   localparam int Depth = 2;

   blk_type     mem_ff [Depth];
   blk_type     mem_in;
   logic [0:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   logic [127:0] raw, padded;
   logic        partial;

   // Pad a partial final block with one marker byte and zeros.
   always_comb begin
      raw = {req_block_high, req_block_low};
      partial = req_final_block && (req_valid_bytes < FULL_BYTES);
      padded = raw;
      if (partial) begin
         for (int i = 0; i < 16; i++) begin
            if (i == int'(req_valid_bytes)) padded[127 - 8 * i -: 8] = PAD_BYTE;
            else if (i > int'(req_valid_bytes)) padded[127 - 8 * i -: 8] = 8'h00;
         end
      end
      mem_in.data        = padded;
      mem_in.use_k1      = req_final_block && !partial;
      mem_in.use_k2      = partial;
      mem_in.restart     = req_restart;
      mem_in.final_block = req_final_block;
   end

   // Short queue between the front and back ends.
   assign req_stall = (count_ff == 2'(Depth));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_data    = mem_ff[rd_ptr_ff];
   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in  = count_ff + 2'(push) - 2'(q_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= mem_in;
   end
endmodule

// ===== rtl/core/cmac_back.sv =====
// Back end: subkey generation, CBC chaining through an iterative AES round unit.
module cmac_back
   import cmac_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [127:0] key,
   input  logic [127:0] start_iv,
   input  logic         key_written,
   input  logic         q_valid,
   input  blk_type      q_data,
   output logic         q_pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [63:0]  rsp_mac_high,
   output logic [63:0]  rsp_mac_low
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SUBK = 2'd1;
   localparam logic [1:0] ST_ENC  = 2'd2;

   logic [1:0]   state_ff, state_in;
   logic [3:0]   round_ff, round_in;
   logic [127:0] st_ff, st_in, rk_ff, rk_in, cv_ff, cv_in, k1_ff, k1_in, k2_ff, k2_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic         cur_ff, cur_in, fin_ff, fin_in;
   logic         ovalid_ff, ovalid_in;
   logic [127:0] mac_ff, mac_in;
   logic [127:0] nk, nst, base, blk, k1n;
   logic         out_free;

   assign out_free = !ovalid_ff || !rsp_stall;
   assign nk  = key_step(rk_ff, rcon_ff);
   assign nst = round_core(st_ff, round_ff == 4'd10) ^ nk;
   assign k1n = gf_dbl(nst);

   // Sequencer: subkey pass when needed, then ten rounds per block.
   always_comb begin
      state_in = state_ff; round_in = round_ff; st_in = st_ff; rk_in = rk_ff;
      rcon_in = rcon_ff; cv_in = cv_ff; k1_in = k1_ff; k2_in = k2_ff;
      cur_in = cur_ff && !key_written; fin_in = fin_ff;
      ovalid_in = ovalid_ff && rsp_stall; mac_in = mac_ff; q_pop = 1'b0;
      base = q_data.restart ? start_iv : cv_ff;
      blk = q_data.data ^ (q_data.use_k1 ? k1_ff : '0) ^ (q_data.use_k2 ? k2_ff : '0);
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && !cur_ff) begin
               state_in = ST_SUBK; st_in = key; rk_in = key;
               rcon_in = 8'h01; round_in = 4'd1;
            end else if (q_valid && out_free) begin
               q_pop = 1'b1; state_in = ST_ENC; st_in = base ^ blk ^ key;
               rk_in = key; rcon_in = 8'h01; round_in = 4'd1;
               fin_in = q_data.final_block;
            end
         end
         ST_SUBK, ST_ENC: begin
            st_in = nst; rk_in = nk; rcon_in = xt(rcon_ff);
            round_in = round_ff + 4'd1;
            if (round_ff == 4'd10) begin
               state_in = ST_IDLE;
               if (state_ff == ST_SUBK) begin
                  k1_in = k1n; k2_in = gf_dbl(k1n); cur_in = !key_written;
               end else begin
                  cv_in = nst;
                  if (fin_ff) begin
                     ovalid_in = 1'b1; mac_in = nst;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; cur_ff <= 1'b0; ovalid_ff <= 1'b0; cv_ff <= '0;
      end else begin
         state_ff <= state_in; cur_ff <= cur_in; ovalid_ff <= ovalid_in; cv_ff <= cv_in;
      end
   end

   always_ff @(posedge clock) begin
      round_ff <= round_in; st_ff <= st_in; rk_ff <= rk_in; rcon_ff <= rcon_in;
      k1_ff <= k1_in; k2_ff <= k2_in; fin_ff <= fin_in; mac_ff <= mac_in;
   end

   assign rsp_valid    = ovalid_ff;
   assign rsp_mac_high = mac_ff[127:64];
   assign rsp_mac_low  = mac_ff[63:0];
endmodule

// ===== rtl/core/aes128_cmac_engine.sv =====
// Top level of the AES-128 CMAC engine.
// Usage: write the key (indexes 0 and 1) and start IV (2 and 3) over the csr_
// channel while the engine is idle; csr_ready is always high.
// Each request on the req_ channel carries one 16-byte block, its valid byte
// count, a final flag and a restart flag. The front end pads the block and
// places it in a two-entry queue, so up to two requests are taken while the
// back end is busy. The back end runs one AES round per cycle: a block is
// loaded and then passes through ten rounds, and no new block starts until
// its last round is done, because of the chaining dependence through the round unit.
// After a key write the first block also waits for the subkey pass. A final
// block yields its MAC on rsp_ from a register loaded at its last round;
// non-final blocks yield nothing. A stalled response holds its value and
// the back end waits before starting a new block until the output is free.
// Synchronous reset clears the key, IV, chaining value and all handshakes.
module aes128_cmac_engine
   import cmac_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_block_high,
   input  logic [63:0] req_block_low,
   input  logic [4:0]  req_valid_bytes,
   input  logic        req_final_block,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_mac_high,
   output logic [63:0] rsp_mac_low,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);
   logic [63:0] key_high_ff, key_low_ff, iv_high_ff, iv_low_ff;
   logic        csr_we, key_written, q_valid, q_pop;
   blk_type     q_data;

   // Configuration registers.
   assign csr_ready   = 1'b1;
   assign csr_we      = csr_valid && csr_ready;
   assign key_written = csr_we && (csr_index == CSR_KEY_HIGH || csr_index == CSR_KEY_LOW);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0; key_low_ff <= '0; iv_high_ff <= '0; iv_low_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KEY_HIGH: key_high_ff <= csr_data;
            CSR_KEY_LOW:  key_low_ff  <= csr_data;
            CSR_IV_HIGH:  iv_high_ff  <= csr_data;
            default:      iv_low_ff   <= csr_data;
         endcase
      end
   end

   cmac_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_block_high, .req_block_low,
      .req_valid_bytes, .req_final_block, .req_restart,
      .q_valid, .q_data, .q_pop
   );

   cmac_back u_back (
      .clock, .reset,
      .key({key_high_ff, key_low_ff}), .start_iv({iv_high_ff, iv_low_ff}),
      .key_written, .q_valid, .q_data, .q_pop,
      .rsp_valid, .rsp_stall, .rsp_mac_high, .rsp_mac_low
   );
endmodule

// ===== rtl/core/cmac_checker.sv =====
// Port-level checker for the CMAC engine, bound to the top level.
module cmac_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_mac_high,
   input logic [63:0] rsp_mac_low,
   input logic        csr_ready
);
   // A stalled response keeps its MAC.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_mac_high) && $stable(rsp_mac_low))
      else $error("response changed while stalled");

   // A taken result is not immediately followed by another.
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid)
      else $error("results too close together");

   // Nothing comes out in the cycle after reset.
   a_rsp_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // The request queue is empty right after reset, so requests are taken.
   a_req_reset: assert property (@(posedge clock) reset |=> !req_stall)
      else $error("request stalled after reset");

   // Configuration is always taken.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("csr not ready");
endmodule

bind aes128_cmac_engine cmac_checker u_cmac_checker (
   .clock, .reset, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_mac_high, .rsp_mac_low, .csr_ready
);
